### rtl/sbq_pkg.sv
// types, constants and register codes shared by the stereo biquad filter
package sbq_pkg;

	localparam int COEF_FRAC_BITS = 20;
	localparam int HIST_FRAC_BITS = 8;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 24;
	localparam int HIST_W   = 32;
	localparam int CFG_IDX_W = 3;

	// product widths of the feedforward and feedback taps
	localparam int FF_PROD_W = COEF_W + SAMPLE_W;
	localparam int FB_PROD_W = COEF_W + HIST_W;
	localparam int FF_SUM_W  = FF_PROD_W + 2;

	// accumulator keeps the exact sum with headroom
	localparam int ACC_W = ((FF_SUM_W + HIST_FRAC_BITS) > FB_PROD_W ?
		(FF_SUM_W + HIST_FRAC_BITS) : FB_PROD_W) + 2;

	localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 24'sd1048576;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_A1 = 3'd3,
		REG_A2 = 3'd4
	} coef_reg_e;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left_sample;
		logic [SAMPLE_W-1:0] right_sample;
	} sample_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left_result;
		logic [SAMPLE_W-1:0] right_result;
	} result_item_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_set_t;

	// past inputs and past outputs of one channel, 1 is one sample back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x1;
		logic signed [SAMPLE_W-1:0] x2;
		logic signed [HIST_W-1:0]   y1;
		logic signed [HIST_W-1:0]   y2;
	} chan_hist_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0]      res;
		logic signed [SAMPLE_W-1:0] x;
		logic signed [HIST_W-1:0] y;
	} chan_out_t;

endpackage

### rtl/stereo_biquad_iir_filter.sv
// stereo direct-form-I biquad, one sample pair per cycle while the result is not stalled
// an accepted item is held in the input register (stage 1) and then shown from the result register
// throughput: one item per cycle while result_stall does not hold the result register; the y history
//   feedback closes through five 24-bit multipliers and one wide adder per channel
// reset: coefficients go to b0 = 1.0 and all others zero, history and valids clear
module stereo_biquad_iir_filter (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_wr_en,
	input  logic [sbq_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [sbq_pkg::COEF_W-1:0]                cfg_data,
	input  logic                                      sample_valid,
	output logic                                      sample_stall,
	input  sbq_pkg::sample_item_t                     sample,
	output logic                                      result_valid,
	input  logic                                      result_stall,
	output sbq_pkg::result_item_t                     result
);

	localparam int AW = sbq_pkg::ACC_W;
	localparam int CF = sbq_pkg::COEF_FRAC_BITS;
	localparam int OF = sbq_pkg::COEF_FRAC_BITS + sbq_pkg::HIST_FRAC_BITS;
	localparam logic signed [AW-1:0] Y_MAX = AW'(64'sd2147483647);
	localparam logic signed [AW-1:0] Y_MIN = AW'(-64'sd2147483648);
	localparam logic signed [AW-1:0] R_MAX = AW'(64'sd32767);
	localparam logic signed [AW-1:0] R_MIN = AW'(-64'sd32768);
	localparam logic signed [AW-1:0] Y_BIAS = AW'((64'sd1 <<< CF) - 64'sd1);
	localparam logic signed [AW-1:0] R_BIAS = AW'((64'sd1 <<< OF) - 64'sd1);
	localparam logic signed [AW-1:0] ACC_ZERO = '0;

	sbq_pkg::coef_set_t    coef_q;
	sbq_pkg::chan_hist_t   left_hist_q;
	sbq_pkg::chan_hist_t   right_hist_q;
	sbq_pkg::sample_item_t item_s1;
	logic                  valid_s1;
	logic                  adv;
	logic                  accept;
	sbq_pkg::chan_out_t    left_filt;
	sbq_pkg::chan_out_t    right_filt;

	// one channel: biquad sum, truncate toward zero, saturate
	function automatic sbq_pkg::chan_out_t chan_filter(
		input logic [sbq_pkg::SAMPLE_W-1:0] raw,
		input sbq_pkg::chan_hist_t           h,
		input sbq_pkg::coef_set_t            c
	);
		sbq_pkg::chan_out_t                     o;
		logic signed [sbq_pkg::SAMPLE_W-1:0]    x;
		logic signed [sbq_pkg::FF_PROD_W-1:0]   pb0;
		logic signed [sbq_pkg::FF_PROD_W-1:0]   pb1;
		logic signed [sbq_pkg::FF_PROD_W-1:0]   pb2;
		logic signed [sbq_pkg::FB_PROD_W-1:0]   pa1;
		logic signed [sbq_pkg::FB_PROD_W-1:0]   pa2;
		logic signed [sbq_pkg::FF_SUM_W-1:0]    ff;
		logic signed [AW-1:0]                   ff_ext;
		logic signed [AW-1:0]                   acc;
		logic signed [AW-1:0]                   ty;
		logic signed [AW-1:0]                   tr;
		logic signed [AW-1:0]                   rs;
		x   = {~raw[sbq_pkg::SAMPLE_W-1], raw[sbq_pkg::SAMPLE_W-2:0]};
		pb0 = c.b0 * x;
		pb1 = c.b1 * h.x1;
		pb2 = c.b2 * h.x2;
		pa1 = c.a1 * h.y1;
		pa2 = c.a2 * h.y2;
		ff  = pb0 + pb1 + pb2;
		ff_ext = ff;
		acc = (ff_ext <<< sbq_pkg::HIST_FRAC_BITS) - pa1 - pa2;
		// negative values get a bias so the arithmetic shift rounds toward zero
		ty = (acc + (acc[AW-1] ? Y_BIAS : ACC_ZERO)) >>> CF;
		tr = (acc + (acc[AW-1] ? R_BIAS : ACC_ZERO)) >>> OF;
		if (ty > Y_MAX)
			ty = Y_MAX;
		else if (ty < Y_MIN)
			ty = Y_MIN;
		if (tr > R_MAX)
			rs = R_MAX;
		else if (tr < R_MIN)
			rs = R_MIN;
		else
			rs = tr;
		o.x   = x;
		o.y   = ty[sbq_pkg::HIST_W-1:0];
		o.res = {~rs[sbq_pkg::SAMPLE_W-1], rs[sbq_pkg::SAMPLE_W-2:0]};
		return o;
	endfunction

	// handshake: stage 1 moves on when the result register is free or being taken
	assign adv          = valid_s1 && (!result_valid || !result_stall);
	assign sample_stall = valid_s1 && !adv;
	assign accept       = sample_valid && !sample_stall;

	assign left_filt  = chan_filter(item_s1.left_sample, left_hist_q, coef_q);
	assign right_filt = chan_filter(item_s1.right_sample, right_hist_q, coef_q);

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= sbq_pkg::COEF_B0_RESET;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sbq_pkg::REG_B0: coef_q.b0 <= cfg_data;
				sbq_pkg::REG_B1: coef_q.b1 <= cfg_data;
				sbq_pkg::REG_B2: coef_q.b2 <= cfg_data;
				sbq_pkg::REG_A1: coef_q.a1 <= cfg_data;
				sbq_pkg::REG_A2: coef_q.a2 <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
		end
	end

	// filter history, updated as each item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_hist_q  <= '0;
			right_hist_q <= '0;
		end else if (adv) begin
			left_hist_q.x2  <= left_hist_q.x1;
			left_hist_q.x1  <= left_filt.x;
			left_hist_q.y2  <= left_hist_q.y1;
			left_hist_q.y1  <= left_filt.y;
			right_hist_q.x2 <= right_hist_q.x1;
			right_hist_q.x1 <= right_filt.x;
			right_hist_q.y2 <= right_hist_q.y1;
			right_hist_q.y1 <= right_filt.y;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			result.left_result  <= left_filt.res;
			result.right_result <= right_filt.res;
		end
	end

	// a stalled input only happens with a full stage 1 and a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled without a blocked result");

	// every item leaving stage 1 lands in the result register
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result_valid)
		else $error("result lost after stage 1");

	// history shifts by one place per item
	a_hist_shift: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (left_hist_q.y2 == $past(left_hist_q.y1) &&
			right_hist_q.x2 == $past(right_hist_q.x1)))
		else $error("history did not shift");

	// history holds while no item leaves stage 1
	a_hist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(left_hist_q) && $stable(right_hist_q)))
		else $error("history changed without an item");

endmodule
